// File: src/linear_interp_resampler_core_macros.svh
// Assertion helpers used by the resampler back end.
`ifndef LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH
`define LINEAR_INTERP_RESAMPLER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/lrs_pkg.sv
`timescale 1ns / 1ps

package lrs_pkg;

   // Field widths.
   localparam int SAMPLE_W   = 16;
   localparam int RATE_W     = 21;
   localparam int GAIN_W     = 16;
   localparam int CHAN_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 21;

   // Register indexes on the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_PLAYBACK_RATE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN          = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 2'd2;

   // Register reset values.
   localparam logic [RATE_W-1:0] RATE_RESET = 21'd65536;
   localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd4096;
   localparam logic [CHAN_W-1:0] CHAN_RESET = 2'd2;

   // Playback rate handling: the register is Q5.16 and is clamped to 1/16 .. 16.
   localparam int                RATE_FRAC_BITS = 16;
   localparam logic [RATE_W-1:0] RATE_UNITY     = 21'd65536;
   localparam logic [RATE_W-1:0] RATE_MIN       = 21'd4096;
   localparam logic [RATE_W-1:0] RATE_MAX       = 21'd1048576;

   // Channels the datapath provides.
   localparam int MAX_CHANNELS = 2;

   // Default fraction width of the read position.
   localparam int FRACTION_BITS_DEFAULT = 16;

   // Depth of the word queue between front and back.
   localparam int JOB_QUEUE_DEPTH = 2;

   // Register stages of the mixing lanes, output register included.
   localparam int MIX_STAGES = 4;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_sample;
      logic signed [SAMPLE_W-1:0] right_sample;
      logic                       final_frame;
   } req_word_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] left_out;
      logic signed [SAMPLE_W-1:0] right_out;
      logic                       run_last;
      logic                       sound_end;
   } rsp_word_type;

   typedef struct packed {
      logic [RATE_W-1:0] playback_rate;
      logic [GAIN_W-1:0] gain;
      logic [CHAN_W-1:0] channel_count;
   } cfg_type;

   // One classified source frame handed from front to back.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] prev_left;
      logic signed [SAMPLE_W-1:0] prev_right;
      logic signed [SAMPLE_W-1:0] cur_left;
      logic signed [SAMPLE_W-1:0] cur_right;
      logic                       has_previous;
      logic                       final_frame;
   } job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_INTERP,
      BK_HOLD
   } back_state_type;

endpackage

// File: src/lrs_front.sv
`timescale 1ns / 1ps

module lrs_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lrs_pkg::req_word_type req_data,
   output logic                 job_valid,
   input  logic                 job_ready,
   output lrs_pkg::job_type     job_data
);

   logic                                 have_prev_ff;
   logic                                 have_prev_in;
   logic signed [lrs_pkg::SAMPLE_W-1:0] prev_left_ff;
   logic signed [lrs_pkg::SAMPLE_W-1:0] prev_left_in;
   logic signed [lrs_pkg::SAMPLE_W-1:0] prev_right_ff;
   logic signed [lrs_pkg::SAMPLE_W-1:0] prev_right_in;
   logic                                 accept;

   // A word is taken whenever the queue has room.
   assign req_ready = job_ready;
   assign job_valid = req_valid;
   assign accept    = req_valid && req_ready;

   // Pair the incoming frame with the one before it.
   always_comb begin
      job_data.prev_left    = prev_left_ff;
      job_data.prev_right   = prev_right_ff;
      job_data.cur_left     = req_data.left_sample;
      job_data.cur_right    = req_data.right_sample;
      job_data.has_previous = have_prev_ff;
      job_data.final_frame  = req_data.final_frame;
   end

   // The final frame ends the sound, so the next frame starts fresh.
   always_comb begin
      have_prev_in  = have_prev_ff;
      prev_left_in  = prev_left_ff;
      prev_right_in = prev_right_ff;
      if (accept) begin
         have_prev_in  = !req_data.final_frame;
         prev_left_in  = req_data.left_sample;
         prev_right_in = req_data.right_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else begin
         have_prev_ff <= have_prev_in;
      end
   end

   always_ff @(posedge clock) begin
      prev_left_ff  <= prev_left_in;
      prev_right_ff <= prev_right_in;
   end

endmodule

// File: src/lrs_queue.sv
`timescale 1ns / 1ps

module lrs_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  lrs_pkg::job_type push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output lrs_pkg::job_type pop_data
);

   localparam int DEPTH = lrs_pkg::JOB_QUEUE_DEPTH;
   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   lrs_pkg::job_type   slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               push;
   logic               pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointer and fill count update; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: src/lrs_lane.sv
`timescale 1ns / 1ps

module lrs_lane #(
   parameter int FRACTION_BITS = lrs_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                advance,
   input  logic signed [lrs_pkg::SAMPLE_W-1:0] sample_a,
   input  logic signed [lrs_pkg::SAMPLE_W-1:0] sample_b,
   input  logic [FRACTION_BITS-1:0]            frac,
   input  logic [lrs_pkg::GAIN_W-1:0]          gain,
   output logic signed [lrs_pkg::SAMPLE_W-1:0] result
);

   localparam int SW      = lrs_pkg::SAMPLE_W;
   localparam int DIFF_W  = SW + 1;
   localparam int BLEND_W = FRACTION_BITS + SW + 2;
   localparam int PROD_W  = BLEND_W + lrs_pkg::GAIN_W + 1;
   localparam int SHIFT_W = FRACTION_BITS + 12;
   localparam int Q_W     = PROD_W - SHIFT_W;

   logic signed [DIFF_W-1:0]             diff;
   logic signed [FRACTION_BITS:0]        frac_s;
   logic signed [lrs_pkg::GAIN_W:0]      gain_s;
   logic signed [SW-1:0]                 base_ff;
   logic signed [BLEND_W-1:0]            slope_ff;
   logic signed [BLEND_W-1:0]            slope_in;
   logic signed [BLEND_W-1:0]            blend_ff;
   logic signed [BLEND_W-1:0]            blend_in;
   logic signed [PROD_W-1:0]             scaled_ff;
   logic signed [PROD_W-1:0]             scaled_in;
   logic [PROD_W-1:0]                    bias;
   logic [PROD_W-1:0]                    rounded;
   logic [Q_W-1:0]                       quot;
   logic signed [SW-1:0]                 result_ff;
   logic signed [SW-1:0]                 result_in;

   // Stage 1: slope term (b - a) * f.
   assign diff     = DIFF_W'(sample_b) - DIFF_W'(sample_a);
   assign frac_s   = $signed({1'b0, frac});
   assign slope_in = BLEND_W'(diff) * BLEND_W'(frac_s);

   // Stage 2: blend = a * ONE + slope, equal to a*(ONE-f) + b*f.
   assign blend_in = (BLEND_W'(base_ff) <<< FRACTION_BITS) + slope_ff;

   // Stage 3: apply the Q4.12 gain.
   assign gain_s    = $signed({1'b0, gain});
   assign scaled_in = PROD_W'(blend_ff) * PROD_W'(gain_s);

   // Stage 4: divide by ONE * 4096 toward zero, then saturate to 16 bits.
   assign bias    = {{Q_W{1'b0}}, {SHIFT_W{scaled_ff[PROD_W-1]}}};
   assign rounded = scaled_ff + bias;
   assign quot    = rounded[PROD_W-1:SHIFT_W];

   always_comb begin
      if ((&quot[Q_W-1:SW-1]) || !(|quot[Q_W-1:SW-1])) begin
         result_in = $signed(quot[SW-1:0]);
      end else if (quot[Q_W-1]) begin
         result_in = $signed({1'b1, {(SW-1){1'b0}}});
      end else begin
         result_in = $signed({1'b0, {(SW-1){1'b1}}});
      end
   end

   // The whole lane moves together; a stall freezes every stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         base_ff   <= sample_a;
         slope_ff  <= slope_in;
         blend_ff  <= blend_in;
         scaled_ff <= scaled_in;
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

// File: src/lrs_back.sv
`timescale 1ns / 1ps
`include "linear_interp_resampler_core_macros.svh"

module lrs_back #(
   parameter int FRACTION_BITS = lrs_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lrs_pkg::cfg_type      cfg,
   input  logic                  job_valid,
   output logic                  job_ready,
   input  lrs_pkg::job_type      job_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output lrs_pkg::rsp_word_type rsp_data
);

   localparam int POS_W    = FRACTION_BITS + 5;
   localparam int UP_SHIFT = (FRACTION_BITS >= lrs_pkg::RATE_FRAC_BITS) ?
                             FRACTION_BITS - lrs_pkg::RATE_FRAC_BITS : 0;
   localparam int DN_SHIFT = (FRACTION_BITS < lrs_pkg::RATE_FRAC_BITS) ?
                             lrs_pkg::RATE_FRAC_BITS - FRACTION_BITS : 0;
   localparam int EXT_W    = lrs_pkg::RATE_W + UP_SHIFT;
   localparam int NST      = lrs_pkg::MIX_STAGES;

   lrs_pkg::back_state_type       state_ff;
   lrs_pkg::back_state_type       state_in;
   logic [POS_W-1:0]              pos_ff;
   logic [POS_W-1:0]              pos_in;
   lrs_pkg::job_type              job_ff;
   lrs_pkg::job_type              job_in;
   logic [lrs_pkg::RATE_W-1:0]    rate_c;
   logic [EXT_W-1:0]              rate_ext;
   logic [POS_W-1:0]              step;
   logic [POS_W-1:0]              pos_step;
   logic [POS_W-1:0]              pos_one;
   logic                          pos_below_one;
   logic                          step_ge_one;
   logic                          step_ge_two;
   logic                          advance;
   logic                          issue;
   logic                          is_last;
   logic                          is_end;
   logic                          use_prev;
   logic [NST-1:0]                vld_ff;
   logic [NST-1:0]                last_ff;
   logic [NST-1:0]                end_ff;
   logic [FRACTION_BITS-1:0]      lane_frac;
   logic signed [lrs_pkg::SAMPLE_W-1:0] left_a;
   logic signed [lrs_pkg::SAMPLE_W-1:0] right_a;
   logic signed [lrs_pkg::SAMPLE_W-1:0] left_q;
   logic signed [lrs_pkg::SAMPLE_W-1:0] right_q;
   logic                          two_channels;

   // Step size: zero means unity, then clamp to 1/16 .. 16 and rescale.
   always_comb begin
      priority if (cfg.playback_rate == '0) begin
         rate_c = lrs_pkg::RATE_UNITY;
      end else if (cfg.playback_rate < lrs_pkg::RATE_MIN) begin
         rate_c = lrs_pkg::RATE_MIN;
      end else if (cfg.playback_rate > lrs_pkg::RATE_MAX) begin
         rate_c = lrs_pkg::RATE_MAX;
      end else begin
         rate_c = cfg.playback_rate;
      end
   end

   assign rate_ext = EXT_W'(rate_c) << UP_SHIFT;
   assign step     = POS_W'(rate_ext >> DN_SHIFT);

   // Position compares against one and two source frames.
   assign pos_one       = POS_W'(1) << FRACTION_BITS;
   assign pos_step      = pos_ff + step;
   assign pos_below_one = !(|pos_ff[POS_W-1:FRACTION_BITS]);
   assign step_ge_one   = |pos_step[POS_W-1:FRACTION_BITS];
   assign step_ge_two   = |pos_step[POS_W-1:FRACTION_BITS+1];

   // The mixing pipeline moves unless the output word is stuck.
   assign advance = !vld_ff[NST-1] || rsp_ready;

   // Sequencer: fetch a frame, emit interpolated words if it has a predecessor, then hold on a final frame.
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      job_in    = job_ff;
      job_ready = 1'b0;
      issue     = 1'b0;
      is_last   = 1'b0;
      is_end    = 1'b0;
      use_prev  = 1'b0;
      unique case (state_ff)
         lrs_pkg::BK_IDLE: begin
            if (job_valid) begin
               job_ready = 1'b1;
               job_in    = job_data;
               priority if (job_data.has_previous) begin
                  state_in = lrs_pkg::BK_INTERP;
               end else if (job_data.final_frame) begin
                  state_in = lrs_pkg::BK_HOLD;
               end else begin
                  state_in = lrs_pkg::BK_IDLE;
               end
            end
         end
         lrs_pkg::BK_INTERP: begin
            use_prev = 1'b1;
            if (pos_below_one) begin
               if (advance) begin
                  issue   = 1'b1;
                  pos_in  = pos_step;
                  is_last = step_ge_one && (!job_ff.final_frame || step_ge_two);
                  is_end  = is_last && job_ff.final_frame;
               end
            end else begin
               pos_in   = pos_ff - pos_one;
               state_in = job_ff.final_frame ? lrs_pkg::BK_HOLD : lrs_pkg::BK_IDLE;
            end
         end
         lrs_pkg::BK_HOLD: begin
            if (pos_below_one) begin
               if (advance) begin
                  issue   = 1'b1;
                  pos_in  = pos_step;
                  is_last = step_ge_one;
                  is_end  = step_ge_one;
               end
            end else begin
               pos_in   = '0;
               state_in = lrs_pkg::BK_IDLE;
            end
         end
         default: begin
            state_in = lrs_pkg::BK_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lrs_pkg::BK_IDLE;
         pos_ff   <= '0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
   end

   // Lane operands: the previous frame while interpolating, the final frame while holding.
   assign left_a    = use_prev ? job_ff.prev_left : job_ff.cur_left;
   assign right_a   = use_prev ? job_ff.prev_right : job_ff.cur_right;
   assign lane_frac = use_prev ? pos_ff[FRACTION_BITS-1:0] : '0;

   lrs_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_left (
      .clock    (clock),
      .advance  (advance),
      .sample_a (left_a),
      .sample_b (job_ff.cur_left),
      .frac     (lane_frac),
      .gain     (cfg.gain),
      .result   (left_q)
   );

   lrs_lane #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_lane_right (
      .clock    (clock),
      .advance  (advance),
      .sample_a (right_a),
      .sample_b (job_ff.cur_right),
      .frac     (lane_frac),
      .gain     (cfg.gain),
      .result   (right_q)
   );

   // Valid bits and word flags travel alongside the lanes.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NST-2:0], issue};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         last_ff <= {last_ff[NST-2:0], is_last};
         end_ff  <= {end_ff[NST-2:0], is_end};
      end
   end

   // Output word; channel 1 reads zero in mono.
   assign two_channels = cfg.channel_count[1] && (lrs_pkg::MAX_CHANNELS >= 2);
   assign rsp_valid    = vld_ff[NST-1];

   always_comb begin
      rsp_data.left_out  = left_q;
      rsp_data.right_out = two_channels ? right_q : '0;
      rsp_data.run_last  = last_ff[NST-1];
      rsp_data.sound_end = end_ff[NST-1];
   end

   `LRS_ASSERT_NOW(a_end_is_last, clock, reset, rsp_valid && rsp_data.sound_end, rsp_data.run_last, "sound end word is not the last word of its frame")
   `LRS_ASSERT_NOW(a_fresh_sound_at_zero, clock, reset, (state_ff == lrs_pkg::BK_IDLE) && job_valid && !job_data.has_previous, pos_ff == '0, "new sound starts with a nonzero read position")
   `LRS_ASSERT_NOW(a_hold_needs_final, clock, reset, state_ff == lrs_pkg::BK_HOLD, job_ff.final_frame, "hold phase entered for a frame that is not final")
   `LRS_ASSERT_NEXT(a_hold_exit_clears, clock, reset, (state_ff == lrs_pkg::BK_HOLD) && !pos_below_one, (state_ff == lrs_pkg::BK_IDLE) && (pos_ff == '0), "end of sound did not clear the read position")

endmodule

// File: src/linear_interp_resampler_core.sv
`timescale 1ns / 1ps

// Linear-interpolation resampler with gain. Source frames (one or two signed 16-bit
// channels) enter on the req_ channel and resampled frames leave on the rsp_ channel.
// A frame is taken into a two-word queue, from which the back end fetches it. A frame
// with a predecessor then issues the output words it causes while the mixing pipeline
// is not stalled, then steps the read position past it; a final frame goes on to emit
// the words of its hold run. The first frame of a sound only gets stored, or, when it
// is also final, emits its hold words. At the lowest playback rate (1/16) a frame
// causes sixteen words, which sets the sustained rate. Words pass through a four-stage
// mixing pipeline (slope multiply, blend, gain multiply, round and saturate), whose
// last register drives the rsp_ channel. The configuration registers (playback_rate,
// gain, channel_count) are written through csr_we/csr_index/csr_wdata and must only
// change while the block is idle.
module linear_interp_resampler_core #(
   parameter int FRACTION_BITS = lrs_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  lrs_pkg::req_word_type            req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output lrs_pkg::rsp_word_type            rsp_data,
   input  logic                             csr_we,
   input  logic [lrs_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lrs_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic [lrs_pkg::RATE_W-1:0] rate_ff;
   logic [lrs_pkg::GAIN_W-1:0] gain_ff;
   logic [lrs_pkg::CHAN_W-1:0] chan_ff;
   lrs_pkg::cfg_type           cfg;
   logic                       front_valid;
   logic                       front_ready;
   lrs_pkg::job_type           front_job;
   logic                       back_valid;
   logic                       back_ready;
   lrs_pkg::job_type           back_job;

   // Configuration registers; unknown indexes are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff <= lrs_pkg::RATE_RESET;
         gain_ff <= lrs_pkg::GAIN_RESET;
         chan_ff <= lrs_pkg::CHAN_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            lrs_pkg::CSR_PLAYBACK_RATE: rate_ff <= csr_wdata[lrs_pkg::RATE_W-1:0];
            lrs_pkg::CSR_GAIN:          gain_ff <= csr_wdata[lrs_pkg::GAIN_W-1:0];
            lrs_pkg::CSR_CHANNEL_COUNT: chan_ff <= csr_wdata[lrs_pkg::CHAN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      cfg.playback_rate = rate_ff;
      cfg.gain          = gain_ff;
      cfg.channel_count = chan_ff;
   end

   lrs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (front_valid),
      .job_ready (front_ready),
      .job_data  (front_job)
   );

   lrs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_data  (front_job),
      .pop_valid  (back_valid),
      .pop_ready  (back_ready),
      .pop_data   (back_job)
   );

   lrs_back #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .job_valid (back_valid),
      .job_ready (back_ready),
      .job_data  (back_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// File: tb/tb_linear_interp_resampler_core.sv
`timescale 1ns / 1ps

module tb_linear_interp_resampler_core;
   import lrs_pkg::*;

   localparam int          SETTLE_CYCLES = 120;
   localparam int          MAX_RUN       = 32;
   localparam int          FRAC_BITS     = FRACTION_BITS_DEFAULT;
   localparam logic [31:0] POS_ONE       = 32'd1 << FRAC_BITS;
   localparam int          GAIN_ONE      = 4096;

   // Index 3 is not a register; a write there must change nothing.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   // Ports of the block.
   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_word_type          req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_word_type          rsp_data;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // Pacing of both channels.
   int send_idle_pct   = 0;
   int rsp_stall_pct   = 0;
   int rsp_hold_cycles = 0;

   // Run statistics.
   int failures      = 0;
   int frames_sent   = 0;
   int words_checked = 0;

   // Shadow copy of the registers.
   logic [RATE_W-1:0] rate_reg;
   logic [GAIN_W-1:0] gain_reg;
   logic [CHAN_W-1:0] chan_reg;

   // Shadow copy of the resampler state.
   logic signed [SAMPLE_W-1:0] held_left;
   logic signed [SAMPLE_W-1:0] held_right;
   logic [31:0]                read_pos;
   logic                       held_valid;

   // Output words still owed by the block, oldest first.
   rsp_word_type predicted_outputs[$];

   linear_interp_resampler_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // Hard limit on the run time.
   initial begin
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   // Read position increment per output word, after the rate clamps.
   function automatic logic [31:0] read_advance();
      logic [31:0] r;
      r = {11'd0, rate_reg};
      if (r == 32'd0) r = {11'd0, RATE_UNITY};
      if (r < {11'd0, RATE_MIN}) r = {11'd0, RATE_MIN};
      if (r > {11'd0, RATE_MAX}) r = {11'd0, RATE_MAX};
      return r;
   endfunction

   // Blend two samples at a fractional position, apply gain, truncate and saturate.
   function automatic logic [SAMPLE_W-1:0] blend_scale(input logic signed [SAMPLE_W-1:0] s0,
                                                        input logic signed [SAMPLE_W-1:0] s1,
                                                        input logic [31:0] frac);
      longint acc;
      longint scaled;
      acc = longint'(s0) * (longint'(POS_ONE) - longint'(frac))
            + longint'(s1) * longint'(frac);
      scaled = (acc * longint'(gain_reg)) / (longint'(POS_ONE) * GAIN_ONE);
      if (scaled > 32767) scaled = 32767;
      if (scaled < -32768) scaled = -32768;
      return scaled[SAMPLE_W-1:0];
   endfunction

   function automatic rsp_word_type make_word(input logic signed [SAMPLE_W-1:0] l0,
                                              input logic signed [SAMPLE_W-1:0] l1,
                                              input logic signed [SAMPLE_W-1:0] r0,
                                              input logic signed [SAMPLE_W-1:0] r1,
                                              input logic [31:0] frac);
      rsp_word_type w;
      w = '0;
      w.left_out = blend_scale(l0, l1, frac);
      if (chan_reg >= 2 && MAX_CHANNELS >= 2) begin
         w.right_out = blend_scale(r0, r1, frac);
      end
      return w;
   endfunction

   // Work out the output words that one accepted source frame causes.
   task automatic resample_frame(input req_word_type frame);
      logic [31:0]  adv;
      rsp_word_type run[$];
      rsp_word_type w;
      adv = read_advance();
      // Interpolate between the held frame and this one.
      if (held_valid) begin
         while (read_pos < POS_ONE && run.size() < MAX_RUN) begin
            run.push_back(make_word(held_left, frame.left_sample, held_right,
                                    frame.right_sample, read_pos));
            read_pos = read_pos + adv;
         end
         read_pos = read_pos - POS_ONE;
      end
      held_left  = frame.left_sample;
      held_right = frame.right_sample;
      held_valid = 1'b1;
      // The final frame repeats itself up to the end of the sound, then state clears.
      if (frame.final_frame) begin
         while (read_pos < POS_ONE && run.size() < MAX_RUN) begin
            run.push_back(make_word(frame.left_sample, frame.left_sample,
                                    frame.right_sample, frame.right_sample, 32'd0));
            read_pos = read_pos + adv;
         end
         held_left  = '0;
         held_right = '0;
         read_pos   = '0;
         held_valid = 1'b0;
      end
      for (int i = 0; i < run.size(); i++) begin
         w = run[i];
         if (i == run.size() - 1) begin
            w.run_last  = 1'b1;
            w.sound_end = frame.final_frame;
         end
         predicted_outputs.push_back(w);
      end
   endtask

   // Offer one frame and wait until the block takes it.
   task automatic send_frame(input req_word_type frame);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= frame;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      resample_frame(frame);
      frames_sent++;
   endtask

   function automatic req_word_type frame_of(input int l, input int r, input bit fin);
      req_word_type f;
      f.left_sample  = l[SAMPLE_W-1:0];
      f.right_sample = r[SAMPLE_W-1:0];
      f.final_frame  = fin;
      return f;
   endfunction

   // Registers change only here, with the block idle.
   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (index)
         CSR_PLAYBACK_RATE: rate_reg = value[RATE_W-1:0];
         CSR_GAIN:          gain_reg = value[GAIN_W-1:0];
         CSR_CHANNEL_COUNT: chan_reg = value[CHAN_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait for every owed word, then give the block time to finish silent work.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (predicted_outputs.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(19))
         0: return 16'h7FFF;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return SAMPLE_W'($urandom());
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_rate();
      case ($urandom_range(9))
         0: return '0;
         1: return CSR_DATA_W'($urandom_range(4095));
         2: return RATE_MIN;
         3: return RATE_MAX;
         4: return CSR_DATA_W'($urandom_range(2097151, RATE_MAX));
         5: return CSR_DATA_W'($urandom_range(RATE_MAX, 196608));
         default: return CSR_DATA_W'($urandom_range(196608, 8192));
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_gain();
      case ($urandom_range(7))
         0: return '0;
         1: return 21'd65535;
         2: return 21'd4096;
         default: return CSR_DATA_W'($urandom_range(65535));
      endcase
   endfunction

   // A sound is a run of frames closed by a final one; a broken sound marks finals at random.
   task automatic send_sound(input int length, input bit broken);
      req_word_type f;
      for (int i = 0; i < length; i++) begin
         f.left_sample  = pick_sample();
         f.right_sample = pick_sample();
         f.final_frame  = broken ? ($urandom_range(3) == 0) : (i == length - 1);
         send_frame(f);
      end
   endtask

   // Receiver pacing, with an optional long hold-off.
   always @(posedge clock) begin
      if (rsp_hold_cycles > 0) begin
         rsp_hold_cycles = rsp_hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   task automatic report_field(input string field, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
      failures++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field,
               $signed(want), $signed(got));
   endtask

   // Compare every accepted output word with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_outputs.size() == 0) begin
            failures++;
            $display("%0t ns: unexpected word, expected none, actual %p", $time, rsp_data);
         end else begin
            want = predicted_outputs.pop_front();
            words_checked++;
            if (rsp_data.left_out !== want.left_out)
               report_field("left_out", want.left_out, rsp_data.left_out);
            if (rsp_data.right_out !== want.right_out)
               report_field("right_out", want.right_out, rsp_data.right_out);
            if (rsp_data.run_last !== want.run_last)
               report_field("run_last", {15'd0, want.run_last}, {15'd0, rsp_data.run_last});
            if (rsp_data.sound_end !== want.sound_end)
               report_field("sound_end", {15'd0, want.sound_end}, {15'd0, rsp_data.sound_end});
         end
      end
   end

   // Sample extremes at the reset settings, and a sound of a single frame.
   task automatic test_reset_defaults();
      send_frame(frame_of(32767, -32768, 1'b0));
      send_frame(frame_of(-32768, 32767, 1'b0));
      send_frame(frame_of(0, -1, 1'b0));
      send_frame(frame_of(-1, 0, 1'b1));
      send_frame(frame_of(1234, -4321, 1'b1));
   endtask

   // Every register at its extremes, clamped rates and unused channel counts.
   task automatic test_register_extremes();
      drain_and_settle();
      write_register(CSR_GAIN, 21'd65535);
      send_frame(frame_of(32767, -32768, 1'b0));
      send_frame(frame_of(-32768, 32767, 1'b1));

      // Zero rate means unity; zero gain silences; zero channels acts as one.
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, 21'd0);
      write_register(CSR_GAIN, 21'd0);
      write_register(CSR_CHANNEL_COUNT, 21'd0);
      send_frame(frame_of(100, 200, 1'b0));
      send_frame(frame_of(300, 400, 1'b1));

      // Tiny rate clamps to 1/16, which gives the longest runs.
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, 21'd1);
      write_register(CSR_GAIN, 21'd4096);
      write_register(CSR_CHANNEL_COUNT, 21'd1);
      send_frame(frame_of(-32768, 5, 1'b0));
      send_frame(frame_of(32767, -5, 1'b1));

      // Oversized rate clamps to 16: frames are passed over, the final one may be silent.
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, 21'h1FFFFF);
      write_register(CSR_CHANNEL_COUNT, 21'd3);
      send_frame(frame_of(32767, 32767, 1'b0));
      send_frame(frame_of(-32768, -32768, 1'b0));
      send_frame(frame_of(1, -1, 1'b0));
      send_frame(frame_of(-2, 2, 1'b1));

      // Fractional rate and gain above unity, after a write to the unused index.
      drain_and_settle();
      write_register(CSR_UNUSED, 21'h1FFFFF);
      write_register(CSR_PLAYBACK_RATE, 21'd98304);
      write_register(CSR_GAIN, 21'd8192);
      write_register(CSR_CHANNEL_COUNT, 21'd2);
      send_frame(frame_of(10000, -10000, 1'b0));
      send_frame(frame_of(-7, 20001, 1'b0));
      send_frame(frame_of(16384, -16385, 1'b1));
   endtask

   // Registers change between frames of one sound, with the block idle.
   task automatic test_midsound_register_change();
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, 21'd40000);
      write_register(CSR_GAIN, 21'd3000);
      send_frame(frame_of(5000, -5000, 1'b0));
      send_frame(frame_of(-12000, 12000, 1'b0));
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, 21'd131072);
      write_register(CSR_GAIN, 21'd20000);
      send_frame(frame_of(30000, -30000, 1'b0));
      send_frame(frame_of(-1000, 1000, 1'b1));
   endtask

   // The receiver holds off long enough for the block to fill and stall its input.
   task automatic test_input_backpressure();
      drain_and_settle();
      write_register(CSR_PLAYBACK_RATE, RATE_MIN);
      write_register(CSR_GAIN, 21'd4096);
      rsp_hold_cycles = 400;
      send_sound(6, 1'b0);
   endtask

   // One pacing phase of random sounds with occasional register changes.
   task automatic run_random_phase(input int idle_pct, input int stall_pct, input int frames);
      int target;
      drain_and_settle();
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      target = frames_sent + frames;
      while (frames_sent < target) begin
         if ($urandom_range(2) == 0) begin
            drain_and_settle();
            if ($urandom_range(1)) write_register(CSR_PLAYBACK_RATE, pick_rate());
            if ($urandom_range(1)) write_register(CSR_GAIN, pick_gain());
            if ($urandom_range(3) == 0)
               write_register(CSR_CHANNEL_COUNT, CSR_DATA_W'($urandom_range(3)));
         end
         send_sound($urandom_range(8, 1), $urandom_range(9) == 0);
      end
      // Close any sound a broken sequence left open.
      send_frame(frame_of($urandom(), $urandom(), 1'b1));
   endtask

   task automatic test_random_sounds();
      run_random_phase(0, 0, 22);
      run_random_phase(78, 0, 22);
      run_random_phase(0, 78, 22);
      run_random_phase(20, 20, 22);
   endtask

   initial begin
      rate_reg   = RATE_RESET;
      gain_reg   = GAIN_RESET;
      chan_reg   = CHAN_RESET;
      held_left  = '0;
      held_right = '0;
      read_pos   = '0;
      held_valid = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_register_extremes();
      test_midsound_register_change();
      test_input_backpressure();
      test_random_sounds();
      drain_and_settle();

      $display("Run covered %0d source frames and %0d resampled words,", frames_sent,
               words_checked);
      $display("across register extremes, mid-sound changes and four pacing phases.");
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
